// ----- rtl/ed25519_pkg.sv -----
// Package for the edwards25519 point add/double core.
// Holds field constants, item kinds, sequencer opcodes and the program ROM.
`timescale 1ns / 1ps
`default_nettype none
package ed25519_pkg;

    localparam int FE_W = 255;

    localparam logic [FE_W-1:0] PRIME_P = {{(FE_W-5){1'b1}}, 5'b01101};

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_ADD    = 2'd1,
        KIND_DOUBLE = 2'd2,
        KIND_READ   = 2'd3
    } t_kind;

    // ALU ops
    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2
    } t_op;

    // Register file slots: 0..3 acc X,Y,Z,T; 4..7 other; 8 d; 9.. scratch
    localparam int SLOT_W = 5;
    localparam logic [SLOT_W-1:0] S_X1 = 5'd0, S_Y1 = 5'd1, S_Z1 = 5'd2, S_T1 = 5'd3;
    localparam logic [SLOT_W-1:0] S_X2 = 5'd4, S_Y2 = 5'd5, S_Z2 = 5'd6, S_T2 = 5'd7;
    localparam logic [SLOT_W-1:0] S_D = 5'd8;
    localparam logic [SLOT_W-1:0] S_U = 5'd9, S_V = 5'd10, S_A = 5'd11, S_B = 5'd12;
    localparam logic [SLOT_W-1:0] S_C = 5'd13, S_DD = 5'd14, S_E = 5'd15, S_F = 5'd16;
    localparam logic [SLOT_W-1:0] S_G = 5'd17, S_H = 5'd18;
    localparam logic [SLOT_W-1:0] S_X3 = 5'd19, S_Y3 = 5'd20, S_Z3 = 5'd21, S_T3 = 5'd22;
    localparam int NSLOT = 23;

    typedef struct packed {
        t_op              op;
        logic [SLOT_W-1:0] dst;
        logic [SLOT_W-1:0] a;
        logic [SLOT_W-1:0] b;
    } t_instr;

    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] ADD_START = 5'd0;
    localparam logic [PC_W-1:0] ADD_END   = 5'd16;
    localparam logic [PC_W-1:0] DBL_START = 5'd17;
    localparam logic [PC_W-1:0] DBL_END   = 5'd30;

    function automatic t_instr prog_rom(input logic [PC_W-1:0] pc);
        t_instr r;
        r = '{OP_ADD, S_U, S_U, S_U};
        case (pc)
            5'd0:  r = '{OP_SUB, S_U, S_Y1, S_X1};
            5'd1:  r = '{OP_SUB, S_V, S_Y2, S_X2};
            5'd2:  r = '{OP_MUL, S_A, S_U, S_V};
            5'd3:  r = '{OP_ADD, S_U, S_Y1, S_X1};
            5'd4:  r = '{OP_ADD, S_V, S_Y2, S_X2};
            5'd5:  r = '{OP_MUL, S_B, S_U, S_V};
            5'd6:  r = '{OP_ADD, S_U, S_T1, S_T1};
            5'd7:  r = '{OP_MUL, S_U, S_U, S_D};
            5'd8:  r = '{OP_MUL, S_C, S_U, S_T2};
            5'd9:  r = '{OP_ADD, S_U, S_Z1, S_Z1};
            5'd10: r = '{OP_MUL, S_DD, S_U, S_Z2};
            5'd11: r = '{OP_SUB, S_E, S_B, S_A};
            5'd12: r = '{OP_SUB, S_F, S_DD, S_C};
            5'd13: r = '{OP_ADD, S_G, S_DD, S_C};
            5'd14: r = '{OP_ADD, S_H, S_B, S_A};
            5'd15: r = '{OP_MUL, S_X3, S_E, S_F};
            5'd16: r = '{OP_MUL, S_Y3, S_G, S_H};
            5'd17: r = '{OP_MUL, S_A, S_X1, S_X1};
            5'd18: r = '{OP_MUL, S_B, S_Y1, S_Y1};
            5'd19: r = '{OP_MUL, S_U, S_Z1, S_Z1};
            5'd20: r = '{OP_ADD, S_C, S_U, S_U};
            5'd21: r = '{OP_ADD, S_H, S_A, S_B};
            5'd22: r = '{OP_ADD, S_U, S_X1, S_Y1};
            5'd23: r = '{OP_MUL, S_U, S_U, S_U};
            5'd24: r = '{OP_SUB, S_E, S_H, S_U};
            5'd25: r = '{OP_SUB, S_G, S_A, S_B};
            5'd26: r = '{OP_ADD, S_F, S_C, S_G};
            5'd27: r = '{OP_MUL, S_X3, S_E, S_F};
            5'd28: r = '{OP_MUL, S_Y3, S_G, S_H};
            5'd29: r = '{OP_MUL, S_T3, S_E, S_H};
            5'd30: r = '{OP_MUL, S_Z3, S_F, S_G};
            default: r = '{OP_ADD, S_U, S_U, S_U};
        endcase
        return r;
    endfunction

    // Add tail shares the last four products with double: after pc 16 jump to 29
    // is not possible (X3/Y3 already done), so the add program finishes with
    // its own T3/Z3 steps, which the sequencer supplies while the pc holds at 16.

endpackage
`default_nettype wire

// ----- rtl/ed25519_alu.sv -----
// Shared modular ALU: add, subtract, multiply mod 2^255-19.
// Multiply is bit-serial (one operand bit per cycle, MSB first). Uses ed25519_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ed25519_alu
    import ed25519_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_go,
    input  wire t_op             i_op,
    input  wire logic [FE_W-1:0] i_a,
    input  wire logic [FE_W-1:0] i_b,
    output logic                 o_done,
    output logic [FE_W-1:0]      o_r
);

    logic [FE_W-1:0] r_acc, n_acc;
    logic [FE_W-1:0] r_a, r_b;
    logic [7:0]      r_cnt, n_cnt;
    logic            r_busy, n_busy;
    logic            r_done, n_done;

    // one conditional modular reduction of a value below 2p
    function automatic logic [FE_W-1:0] red1(input logic [FE_W:0] v);
        logic [FE_W:0] s;
        s = v - {1'b0, PRIME_P};
        return s[FE_W] ? v[FE_W-1:0] : s[FE_W-1:0];
    endfunction

    logic [FE_W:0]   w_dbl, w_sum, w_diff;
    logic [FE_W-1:0] w_dr;
    logic [FE_W-1:0] w_addend;

    always_comb begin
        w_dbl    = {r_acc, 1'b0};
        w_dr     = red1(w_dbl);
        w_addend = r_a[FE_W-1] ? r_b : {FE_W{1'b0}};
        w_sum    = {1'b0, w_dr} + {1'b0, w_addend};
        w_diff   = {1'b0, i_a} - {1'b0, i_b};
    end

    always_comb begin
        n_acc  = r_acc;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_go) begin
            case (i_op)
                OP_ADD: begin
                    n_acc  = red1({1'b0, i_a} + {1'b0, i_b});
                    n_done = 1'b1;
                end
                OP_SUB: begin
                    n_acc  = w_diff[FE_W] ? (w_diff[FE_W-1:0] + PRIME_P) : w_diff[FE_W-1:0];
                    n_done = 1'b1;
                end
                OP_MUL: begin
                    n_acc  = '0;
                    n_cnt  = 8'(FE_W);
                    n_busy = 1'b1;
                end
                default: n_done = 1'b1;
            endcase
        end else if (r_busy) begin
            n_acc = red1(w_sum);
            n_cnt = r_cnt - 8'd1;
            if (r_cnt == 8'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_acc <= n_acc;
        if (i_go) begin
            r_a <= i_a;
            r_b <= i_b;
        end else if (r_busy) begin
            r_a <= {r_a[FE_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_r    = r_acc;

    property p_no_go_busy;
        @(posedge i_clk) disable iff (!i_rst_n) r_busy |-> !i_go;
    endproperty
    a_no_go_busy: assert property (p_no_go_busy) else $error("go while busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done || $past(i_go)) else $error("done held");

    a_cnt_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_cnt != 8'd0) else $error("busy with zero count");

endmodule
`default_nettype wire

// ----- rtl/edwards25519_point_add_double_core.sv -----
// Top level of the edwards25519 point add/double core.
// Depends on ed25519_pkg and ed25519_alu.
`timescale 1ns / 1ps
`default_nettype none
// A read item emits sixteen limbs back to back (o_valid strobe; the receiver
// cannot stall), X limbs 0..3 first, then Y, Z, T, with o_last on the final
// one. An add runs 19 field operations (9 multiplies) and a double 14 (8
// multiplies) on one shared modular ALU; each add/sub is an issue and a done,
// each multiply an issue, 255 steps of one operand bit each, and a done. A step
// that canonicalizes the stored coordinates and d comes before the program.
// busy is high while an item is in work; start is taken only while busy is low.
// Config writes to d are accepted at any time and must be made while idle.
module edwards25519_point_add_double_core
    import ed25519_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_kind,
    input  wire logic [2:0]  i_coord_sel,
    input  wire logic [1:0]  i_limb_index,
    input  wire logic [63:0] i_limb_value,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    output logic             o_valid,
    output logic [1:0]       o_out_coord,
    output logic [1:0]       o_out_limb,
    output logic [63:0]      o_out_value,
    output logic             o_last
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CANON = 5'b00010,
        ST_ISSUE = 5'b00100,
        ST_WAIT  = 5'b01000,
        ST_READ  = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [255:0]    r_raw [8];     // acc X..T, other X..T as written
    logic [255:0]    r_d;
    logic [FE_W-1:0] r_rf [NSLOT];  // canonical working slots
    logic [PC_W-1:0] r_pc;
    logic            r_dbl;
    logic [3:0]      r_cnt;
    logic            r_tail;        // add: running the T3/Z3 products

    function automatic logic [FE_W-1:0] canon(input logic [255:0] v);
        logic [FE_W:0] s;
        logic [FE_W:0] t;
        s = {1'b0, v[FE_W-1:0]} + (v[255] ? (FE_W+1)'(19) : '0);
        s = {1'b0, s[FE_W-1:0]} + (s[FE_W] ? (FE_W+1)'(19) : '0);
        t = s + (FE_W+1)'(19);
        return t[FE_W] ? t[FE_W-1:0] : s[FE_W-1:0];
    endfunction

    t_instr          w_ins;
    logic            w_go, w_done;
    logic [FE_W-1:0] w_r;

    always_comb begin
        w_ins = prog_rom(r_pc);
        if (r_tail) begin
            w_ins = (r_cnt[0]) ? t_instr'{OP_MUL, S_Z3, S_F, S_G}
                               : t_instr'{OP_MUL, S_T3, S_E, S_H};
        end
    end

    assign w_go = (r_state == ST_ISSUE);

    ed25519_alu u_alu (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_go   (w_go),
        .i_op   (w_ins.op),
        .i_a    (r_rf[w_ins.a]),
        .i_b    (r_rf[w_ins.b]),
        .o_done (w_done),
        .o_r    (w_r)
    );

    logic w_accept, w_last_ins;
    assign w_accept   = start && !busy;
    assign w_last_ins = r_dbl ? (r_pc == DBL_END) : (r_tail && r_cnt[0]);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (w_accept) begin
                case (t_kind'(i_kind))
                    KIND_ADD, KIND_DOUBLE: n_state = ST_CANON;
                    KIND_READ:             n_state = ST_READ;
                    default:               n_state = ST_IDLE;
                endcase
            end
            ST_CANON: n_state = ST_ISSUE;
            ST_ISSUE: n_state = ST_WAIT;
            ST_WAIT:  if (w_done) n_state = w_last_ins ? ST_IDLE : ST_ISSUE;
            ST_READ:  if (r_cnt == 4'd15) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_d     <= '0;
            for (int k = 0; k < 4; k++) r_raw[k] <= '0;
            r_pc    <= '0;
            r_dbl   <= 1'b0;
            r_cnt   <= '0;
            r_tail  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_d[i_cfg_index*64 +: 64] <= i_cfg_data;
            case (r_state)
                ST_IDLE: if (w_accept) begin
                    r_dbl  <= (t_kind'(i_kind) == KIND_DOUBLE);
                    r_pc   <= (t_kind'(i_kind) == KIND_DOUBLE) ? DBL_START : ADD_START;
                    r_cnt  <= '0;
                    r_tail <= 1'b0;
                    if (t_kind'(i_kind) == KIND_LOAD)
                        r_raw[i_coord_sel][i_limb_index*64 +: 64] <= i_limb_value;
                end
                ST_WAIT: if (w_done) begin
                    // both programs end on the Z3 product
                    if (w_last_ins) begin
                        r_raw[0] <= {1'b0, r_rf[S_X3]};
                        r_raw[1] <= {1'b0, r_rf[S_Y3]};
                        r_raw[2] <= {1'b0, w_r};
                        r_raw[3] <= {1'b0, r_rf[S_T3]};
                    end
                    if (r_tail) r_cnt <= r_cnt + 4'd1;
                    else if (!r_dbl && r_pc == ADD_END) r_tail <= 1'b1;
                    else r_pc <= r_pc + 5'd1;
                end
                ST_READ: r_cnt <= r_cnt + 4'd1;
                default: ;
            endcase
        end
    end

    // working slots
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CANON) begin
            for (int k = 0; k < 8; k++) r_rf[k] <= canon(r_raw[k]);
            r_rf[S_D] <= canon(r_d);
        end else if (r_state == ST_WAIT && w_done) begin
            r_rf[w_ins.dst] <= w_r;
        end
    end

    logic [FE_W-1:0] w_rd;
    assign w_rd = canon(r_raw[{1'b0, r_cnt[3:2]}]);

    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = (r_state == ST_READ);
    assign o_out_coord = r_cnt[3:2];
    assign o_out_limb  = r_cnt[1:0];
    assign o_out_value = 64'({1'b0, w_rd} >> (r_cnt[1:0] * 64));
    assign o_last      = o_valid && (r_cnt == 4'd15);

    a_read_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |=> !o_valid) else $error("read run too long");
    a_no_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WAIT) |-> busy) else $error("idle during work");
    a_issue_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ISSUE) |=> (r_state == ST_WAIT)) else $error("issue skipped");

endmodule
`default_nettype wire
